>>> design/dlte_pkg.sv
// Dense layer training engine: shared package.
// Opcodes, state and loop types, output item struct, saturation helpers.
// No dependencies.
`default_nettype none

package dlte_pkg;

    localparam int IN_WIDTH_DEFAULT   = 16;
    localparam int OUT_WIDTH_DEFAULT  = 16;
    localparam int BATCH_ROWS_DEFAULT = 8;

    localparam int          ACC_W      = 40;
    localparam int          GRAD_W     = 32;
    localparam int          DATA_W     = 16;
    localparam int          IDX_W      = 6;
    localparam int          OPC_W      = 3;
    localparam logic [15:0] LR_RESET   = 16'd655;

    localparam logic [OPC_W-1:0] OP_LOAD_W = 3'd0;
    localparam logic [OPC_W-1:0] OP_LOAD_B = 3'd1;
    localparam logic [OPC_W-1:0] OP_FWD    = 3'd2;
    localparam logic [OPC_W-1:0] OP_GRAD   = 3'd3;
    localparam logic [OPC_W-1:0] OP_UPDATE = 3'd4;

    localparam logic KIND_FWD  = 1'b0;
    localparam logic KIND_GRAD = 1'b1;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_DECODE,
        ST_GCLR,
        ST_LOOP,
        ST_DRAIN,
        ST_EMRD,
        ST_EMOUT
    } state_t;

    typedef enum logic [1:0] {
        LP_FWD,
        LP_GRD,
        LP_UPW,
        LP_UPB
    } loop_t;

    typedef struct packed {
        logic                     kind;
        logic [IDX_W-1:0]         out_row;
        logic [IDX_W-1:0]         out_index;
        logic signed [DATA_W-1:0] result;
        logic                     last;
    } out_item_t;

    function automatic logic signed [DATA_W-1:0] sat16(input logic signed [63:0] v);
        logic signed [DATA_W-1:0] r;
        if (v > 64'sd32767)
            r = 16'sh7fff;
        else if (v < -64'sd32768)
            r = 16'sh8000;
        else
            r = v[DATA_W-1:0];
        return r;
    endfunction

    function automatic logic signed [GRAD_W-1:0] sat32(input logic signed [63:0] v);
        logic signed [GRAD_W-1:0] r;
        if (v > 64'sd2147483647)
            r = 32'sh7fffffff;
        else if (v < -64'sd2147483648)
            r = 32'sh80000000;
        else
            r = v[GRAD_W-1:0];
        return r;
    endfunction

endpackage

`default_nettype wire

>>> design/dlte_ram.sv
// Dense layer training engine: generic single-port-write RAM, registered read.
// No dependencies.
`default_nettype none

module dlte_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

>>> design/dlte_out_reg.sv
// Dense layer training engine: output request register.
// Depends on dlte_pkg (out_item_t).
`default_nettype none

module dlte_out_reg (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               load,
    input  wire dlte_pkg::out_item_t item,
    output logic                    free,
    output logic                    out_valid,
    input  wire logic               out_stall,
    output dlte_pkg::out_item_t     out_item
);

    logic                valid_reg;
    dlte_pkg::out_item_t item_reg;

    assign free = !valid_reg || !out_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (load)
        begin
            valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            item_reg <= item;
        end
    end

    assign out_valid = valid_reg;
    assign out_item  = item_reg;

endmodule

`default_nettype wire

>>> design/dense_layer_train_engine.sv
// Dense layer training engine: top level, sequencer and arithmetic pipeline.
// Depends on dlte_pkg, dlte_ram, dlte_out_reg.
//
// One request is taken at a time. After reset a clearing pass over all IN_WIDTH*OUT_WIDTH
// weight addresses zeroes weights, biases and gradients; no request is taken meanwhile.
// Loads are written in the decode state. A forward element loops over OUT_WIDTH outputs,
// a gradient element over IN_WIDTH inputs, after a sweep of the gradient stores to clear
// them when it opens a pass. At a row end each result is read and then loaded into the
// output register, waiting while the output is stalled. Update walks all weights, then
// all biases, with one read-modify-write per cycle on the state memories.
`default_nettype none

module dense_layer_train_engine #(
    parameter int IN_WIDTH   = dlte_pkg::IN_WIDTH_DEFAULT,
    parameter int OUT_WIDTH  = dlte_pkg::OUT_WIDTH_DEFAULT,
    parameter int BATCH_ROWS = dlte_pkg::BATCH_ROWS_DEFAULT
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_write,
    input  wire logic [15:0] cfg_data,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [2:0]  opcode,
    input  wire logic [5:0]  row_index,
    input  wire logic [5:0]  col_index,
    input  wire logic signed [15:0] value,
    input  wire logic        first,
    input  wire logic        row_last,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic             kind,
    output logic [5:0]       out_row,
    output logic [5:0]       out_index,
    output logic signed [15:0] result,
    output logic             last
);

    localparam int NW  = IN_WIDTH * OUT_WIDTH;
    localparam int XD  = BATCH_ROWS * IN_WIDTH;
    localparam int AD  = (IN_WIDTH > OUT_WIDTH) ? IN_WIDTH : OUT_WIDTH;
    localparam int WAW = (NW > 1) ? $clog2(NW) : 1;
    localparam int BAW = (OUT_WIDTH > 1) ? $clog2(OUT_WIDTH) : 1;
    localparam int XAW = (XD > 1) ? $clog2(XD) : 1;
    localparam int AAW = (AD > 1) ? $clog2(AD) : 1;
    localparam int KW  = WAW;

    // control registers
    dlte_pkg::state_t state_reg, state_next;
    dlte_pkg::loop_t  loop_reg, loop_next;
    logic [KW-1:0]    k_reg, k_next;
    logic [2:0]       op_reg;
    logic [5:0]       row_reg, col_reg;
    logic signed [15:0] val_reg;
    logic             first_reg, rlast_reg;
    logic [15:0]      lr_reg;
    logic [AD-1:0]    acc_vld_reg, acc_vld_next;

    // pipeline
    logic               issue;
    logic               s1_vld_reg, s2_vld_reg;
    dlte_pkg::loop_t    s1_loop_reg, s2_loop_reg;
    logic [KW-1:0]      s1_k_reg, s2_k_reg;
    logic signed [31:0] s2_mul1_reg, s2_mul2_reg;
    logic signed [48:0] s2_mulu_reg;
    logic signed [39:0] s2_acc_reg;
    logic signed [31:0] s2_wg_reg, s2_bg_reg;
    logic signed [15:0] s2_old_reg;

    // memories
    logic            w_we, b_we, wg_we, bg_we, x_we, a_we;
    logic [WAW-1:0]  w_waddr, w_raddr, wg_waddr;
    logic [BAW-1:0]  b_waddr, b_raddr, bg_waddr, bg_raddr;
    logic [XAW-1:0]  x_waddr, x_raddr;
    logic [AAW-1:0]  a_waddr, a_raddr;
    logic [15:0]     w_wdata, b_wdata, x_wdata, w_rd, b_rd, x_rd;
    logic [31:0]     wg_wdata, bg_wdata, wg_rd, bg_rd;
    logic [39:0]     a_wdata, a_rd;

    // misc
    logic               col_in_ok, col_out_ok, row_ok, is_grad, in_accept;
    logic [KW-1:0]      loop_last, emit_last;
    logic signed [39:0] acc_s1, acc_emit;
    logic signed [31:0] mul1, mul2;
    logic signed [48:0] mulu;
    logic signed [15:0] x_sel;
    logic signed [39:0] acc_sum;
    logic signed [31:0] wg_sum, bg_sum;
    logic signed [63:0] upd_d;
    logic signed [15:0] upd_new;
    logic signed [41:0] emit_t;
    logic               out_free, emit_load;
    dlte_pkg::out_item_t emit_item, out_item;

    assign in_accept  = in_valid && !in_stall;
    assign col_in_ok  = 32'(col_reg) < IN_WIDTH;
    assign col_out_ok = 32'(col_reg) < OUT_WIDTH;
    assign row_ok     = 32'(row_reg) < BATCH_ROWS;
    assign is_grad    = (op_reg == dlte_pkg::OP_GRAD);
    assign emit_last  = is_grad ? KW'(IN_WIDTH - 1) : KW'(OUT_WIDTH - 1);

    always_comb
    begin
        case (loop_reg)
            dlte_pkg::LP_FWD: loop_last = KW'(OUT_WIDTH - 1);
            dlte_pkg::LP_GRD: loop_last = KW'(IN_WIDTH - 1);
            dlte_pkg::LP_UPW: loop_last = KW'(NW - 1);
            default:          loop_last = KW'(OUT_WIDTH - 1);
        endcase
    end

    // read addresses
    always_comb
    begin
        case (loop_reg)
            dlte_pkg::LP_FWD: w_raddr = WAW'(col_reg * OUT_WIDTH + k_reg);
            dlte_pkg::LP_GRD: w_raddr = WAW'(k_reg * OUT_WIDTH + col_reg);
            default:          w_raddr = WAW'(k_reg);
        endcase
    end
    assign b_raddr  = BAW'(k_reg);
    assign bg_raddr = (loop_reg == dlte_pkg::LP_GRD) ? BAW'(col_reg) : BAW'(k_reg);
    assign x_raddr  = XAW'(row_reg * IN_WIDTH + k_reg);
    assign a_raddr  = AAW'(k_reg);

    // stage 1: memory data valid, multiply
    assign acc_s1 = acc_vld_reg[AAW'(s1_k_reg)] ? $signed(a_rd) : 40'sd0;
    assign x_sel  = row_ok ? $signed(x_rd) : 16'sd0;
    assign mul1   = val_reg * $signed(w_rd);
    assign mul2   = x_sel * val_reg;
    assign mulu   = $signed({1'b0, lr_reg})
                    * ((s1_loop_reg == dlte_pkg::LP_UPB) ? $signed(bg_rd) : $signed(wg_rd));

    always_ff @(posedge clk)
    begin
        s1_loop_reg <= loop_reg;
        s1_k_reg    <= k_reg;
        s2_loop_reg <= s1_loop_reg;
        s2_k_reg    <= s1_k_reg;
        s2_mul1_reg <= mul1;
        s2_mul2_reg <= mul2;
        s2_mulu_reg <= mulu;
        s2_acc_reg  <= acc_s1;
        s2_wg_reg   <= $signed(wg_rd);
        s2_bg_reg   <= $signed(bg_rd);
        s2_old_reg  <= (s1_loop_reg == dlte_pkg::LP_UPB) ? $signed(b_rd) : $signed(w_rd);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_vld_reg <= 1'b0;
            s2_vld_reg <= 1'b0;
        end
        else
        begin
            s1_vld_reg <= issue;
            s2_vld_reg <= s1_vld_reg;
        end
    end

    // stage 2: accumulate and write back
    assign acc_sum = s2_acc_reg + 40'(s2_mul1_reg);
    assign wg_sum  = dlte_pkg::sat32(64'(s2_wg_reg) + 64'(s2_mul2_reg));
    assign bg_sum  = dlte_pkg::sat32(64'(s2_bg_reg) + 64'(val_reg));
    assign upd_d   = (s2_loop_reg == dlte_pkg::LP_UPB)
                     ? ((64'(s2_mulu_reg) + 64'sd32768) >>> 16)
                     : ((64'(s2_mulu_reg) + 64'sd8388608) >>> 24);
    assign upd_new = dlte_pkg::sat16(64'(s2_old_reg) - upd_d);

    // emission
    assign acc_emit = acc_vld_reg[AAW'(k_reg)] ? $signed(a_rd) : 40'sd0;
    assign emit_t   = 42'(acc_emit) + (is_grad ? 42'sd0 : (42'($signed(b_rd)) <<< 8))
                      + 42'sd128;
    assign emit_item.kind      = is_grad ? dlte_pkg::KIND_GRAD : dlte_pkg::KIND_FWD;
    assign emit_item.out_row   = row_reg;
    assign emit_item.out_index = 6'(k_reg);
    assign emit_item.result    = dlte_pkg::sat16(64'(emit_t >>> 8));
    assign emit_item.last      = (k_reg == emit_last);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= dlte_pkg::ST_CLEAR;
            loop_reg    <= dlte_pkg::LP_FWD;
            k_reg       <= '0;
            acc_vld_reg <= '0;
            lr_reg      <= dlte_pkg::LR_RESET;
        end
        else
        begin
            state_reg   <= state_next;
            loop_reg    <= loop_next;
            k_reg       <= k_next;
            acc_vld_reg <= acc_vld_next;
            if (cfg_write)
            begin
                lr_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            op_reg    <= opcode;
            row_reg   <= row_index;
            col_reg   <= col_index;
            val_reg   <= value;
            first_reg <= first;
            rlast_reg <= row_last;
        end
    end

    always_comb
    begin
        state_next   = state_reg;
        loop_next    = loop_reg;
        k_next       = k_reg;
        acc_vld_next = acc_vld_reg;
        in_stall     = 1'b1;
        issue        = 1'b0;
        emit_load    = 1'b0;

        // pipeline write-back
        w_we     = s2_vld_reg && (s2_loop_reg == dlte_pkg::LP_UPW);
        w_waddr  = WAW'(s2_k_reg);
        w_wdata  = upd_new;
        b_we     = s2_vld_reg && (s2_loop_reg == dlte_pkg::LP_UPB);
        b_waddr  = BAW'(s2_k_reg);
        b_wdata  = upd_new;
        wg_we    = s2_vld_reg && (s2_loop_reg == dlte_pkg::LP_GRD);
        wg_waddr = WAW'(s2_k_reg * OUT_WIDTH + col_reg);
        wg_wdata = wg_sum;
        bg_we    = s2_vld_reg && (s2_loop_reg == dlte_pkg::LP_GRD) && (s2_k_reg == '0);
        bg_waddr = BAW'(col_reg);
        bg_wdata = bg_sum;
        a_we     = s2_vld_reg && ((s2_loop_reg == dlte_pkg::LP_FWD)
                                  || (s2_loop_reg == dlte_pkg::LP_GRD));
        a_waddr  = AAW'(s2_k_reg);
        a_wdata  = acc_sum;
        x_we     = 1'b0;
        x_waddr  = XAW'(row_reg * IN_WIDTH + col_reg);
        x_wdata  = val_reg;
        if (a_we)
        begin
            acc_vld_next[AAW'(s2_k_reg)] = 1'b1;
        end

        unique case (state_reg)
            dlte_pkg::ST_CLEAR:
            begin
                w_we     = 1'b1;
                w_waddr  = WAW'(k_reg);
                w_wdata  = '0;
                wg_we    = 1'b1;
                wg_waddr = WAW'(k_reg);
                wg_wdata = '0;
                b_we     = 32'(k_reg) < OUT_WIDTH;
                b_waddr  = BAW'(k_reg);
                b_wdata  = '0;
                bg_we    = b_we;
                bg_waddr = BAW'(k_reg);
                bg_wdata = '0;
                if (k_reg == KW'(NW - 1))
                begin
                    k_next     = '0;
                    state_next = dlte_pkg::ST_IDLE;
                end
                else
                begin
                    k_next = k_reg + 1'b1;
                end
            end
            dlte_pkg::ST_IDLE:
            begin
                in_stall = 1'b0;
                k_next   = '0;
                if (in_valid)
                begin
                    state_next = dlte_pkg::ST_DECODE;
                end
            end
            dlte_pkg::ST_DECODE:
            begin
                state_next = dlte_pkg::ST_IDLE;
                case (op_reg)
                    dlte_pkg::OP_LOAD_W:
                    begin
                        w_we    = (32'(row_reg) < IN_WIDTH) && col_out_ok;
                        w_waddr = WAW'(row_reg * OUT_WIDTH + col_reg);
                        w_wdata = val_reg;
                    end
                    dlte_pkg::OP_LOAD_B:
                    begin
                        b_we    = col_out_ok;
                        b_waddr = BAW'(col_reg);
                        b_wdata = val_reg;
                    end
                    dlte_pkg::OP_FWD:
                    begin
                        if (first_reg)
                        begin
                            acc_vld_next = '0;
                        end
                        x_we      = col_in_ok && row_ok;
                        loop_next = dlte_pkg::LP_FWD;
                        state_next = col_in_ok ? dlte_pkg::ST_LOOP : dlte_pkg::ST_DRAIN;
                    end
                    dlte_pkg::OP_GRAD:
                    begin
                        loop_next = dlte_pkg::LP_GRD;
                        if (first_reg)
                        begin
                            acc_vld_next = '0;
                            state_next   = dlte_pkg::ST_GCLR;
                        end
                        else
                        begin
                            state_next = col_out_ok ? dlte_pkg::ST_LOOP : dlte_pkg::ST_DRAIN;
                        end
                    end
                    dlte_pkg::OP_UPDATE:
                    begin
                        loop_next  = dlte_pkg::LP_UPW;
                        state_next = dlte_pkg::ST_LOOP;
                    end
                    default:
                    begin
                        state_next = dlte_pkg::ST_IDLE;
                    end
                endcase
            end
            dlte_pkg::ST_GCLR:
            begin
                wg_we    = 1'b1;
                wg_waddr = WAW'(k_reg);
                wg_wdata = '0;
                bg_we    = 32'(k_reg) < OUT_WIDTH;
                bg_waddr = BAW'(k_reg);
                bg_wdata = '0;
                if (k_reg == KW'(NW - 1))
                begin
                    k_next     = '0;
                    state_next = col_out_ok ? dlte_pkg::ST_LOOP : dlte_pkg::ST_DRAIN;
                end
                else
                begin
                    k_next = k_reg + 1'b1;
                end
            end
            dlte_pkg::ST_LOOP:
            begin
                issue = 1'b1;
                if (k_reg == loop_last)
                begin
                    k_next = '0;
                    if (loop_reg == dlte_pkg::LP_UPW)
                    begin
                        loop_next = dlte_pkg::LP_UPB;
                    end
                    else
                    begin
                        state_next = dlte_pkg::ST_DRAIN;
                    end
                end
                else
                begin
                    k_next = k_reg + 1'b1;
                end
            end
            dlte_pkg::ST_DRAIN:
            begin
                k_next = '0;
                if (!s1_vld_reg && !s2_vld_reg)
                begin
                    if (rlast_reg && ((op_reg == dlte_pkg::OP_FWD) || is_grad))
                    begin
                        state_next = dlte_pkg::ST_EMRD;
                    end
                    else
                    begin
                        state_next = dlte_pkg::ST_IDLE;
                    end
                end
            end
            dlte_pkg::ST_EMRD:
            begin
                state_next = dlte_pkg::ST_EMOUT;
            end
            dlte_pkg::ST_EMOUT:
            begin
                if (out_free)
                begin
                    emit_load = 1'b1;
                    if (k_reg == emit_last)
                    begin
                        acc_vld_next = '0;
                        k_next       = '0;
                        state_next   = dlte_pkg::ST_IDLE;
                    end
                    else
                    begin
                        k_next     = k_reg + 1'b1;
                        state_next = dlte_pkg::ST_EMRD;
                    end
                end
            end
            default:
            begin
                state_next = dlte_pkg::ST_IDLE;
            end
        endcase
    end

    dlte_ram #(.WIDTH(16), .DEPTH(NW)) u_w_ram (
        .clk(clk), .we(w_we), .waddr(w_waddr), .wdata(w_wdata),
        .raddr(w_raddr), .rdata(w_rd)
    );

    dlte_ram #(.WIDTH(32), .DEPTH(NW)) u_wg_ram (
        .clk(clk), .we(wg_we), .waddr(wg_waddr), .wdata(wg_wdata),
        .raddr(w_raddr), .rdata(wg_rd)
    );

    dlte_ram #(.WIDTH(16), .DEPTH(OUT_WIDTH)) u_b_ram (
        .clk(clk), .we(b_we), .waddr(b_waddr), .wdata(b_wdata),
        .raddr(b_raddr), .rdata(b_rd)
    );

    dlte_ram #(.WIDTH(32), .DEPTH(OUT_WIDTH)) u_bg_ram (
        .clk(clk), .we(bg_we), .waddr(bg_waddr), .wdata(bg_wdata),
        .raddr(bg_raddr), .rdata(bg_rd)
    );

    dlte_ram #(.WIDTH(16), .DEPTH(XD)) u_x_ram (
        .clk(clk), .we(x_we), .waddr(x_waddr), .wdata(x_wdata),
        .raddr(x_raddr), .rdata(x_rd)
    );

    dlte_ram #(.WIDTH(40), .DEPTH(AD)) u_acc_ram (
        .clk(clk), .we(a_we), .waddr(a_waddr), .wdata(a_wdata),
        .raddr(a_raddr), .rdata(a_rd)
    );

    dlte_out_reg u_out (
        .clk(clk), .rst_n(rst_n), .load(emit_load), .item(emit_item), .free(out_free),
        .out_valid(out_valid), .out_stall(out_stall), .out_item(out_item)
    );

    assign kind      = out_item.kind;
    assign out_row   = out_item.out_row;
    assign out_index = out_item.out_index;
    assign result    = out_item.result;
    assign last      = out_item.last;

    a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
        emit_load |-> out_free)
        else $error("result loaded into a busy output register");

    a_s2_follows_s1: assert property (@(posedge clk) disable iff (!rst_n)
        s2_vld_reg |-> $past(s1_vld_reg))
        else $error("write-back without a preceding read stage");

    a_emit_drained: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == dlte_pkg::ST_EMRD |-> (!s1_vld_reg && !s2_vld_reg))
        else $error("emission started with accumulator writes in flight");

endmodule

`default_nettype wire
